// ===== design/etr_pkg.sv =====
// Event trigger recorder package: payload structs, request codes, control types,
// command and status structs shared by the controller and the datapath.
// No dependencies.
`default_nettype none

package etr_pkg;

  localparam int unsigned RingDepthDefault  = 2048;
  localparam int unsigned EventCountDefault = 8;
  localparam int unsigned DefSlots          = 8;
  localparam int unsigned DefW              = 56;
  localparam int unsigned CfgIdxW           = 4;
  localparam int unsigned EvtIdxW           = 3;
  localparam int unsigned LineW             = 16;
  localparam int unsigned ModeW             = 7;

  localparam logic [DefW-1:0] Def0Reset = 56'h00FF0000FFFF0000;

  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_READ   = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_type_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MATCH,
    ST_TAIL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] sample;
  } in_word_t;

  typedef struct packed {
    logic        read_valid;
    logic [63:0] read_data;
    logic [6:0]  mode;
    logic [7:0]  overflow_count;
    logic [7:0]  match_bits;
    logic [3:0]  pushes_tried;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic               capture;   // latch the incoming word, clear accumulators
    logic               rd_issue;  // read oldest entry, advance read pointer
    logic               clear_buf; // read pointer jumps to write pointer
    logic               step;      // check one event definition
    logic [EvtIdxW-1:0] evt_idx;
    logic               tail;      // trailing push in mode 3, latch lines
    logic               load_out;  // move result into output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] req_type;
    logic       smp_zero;
    logic       empty;
  } status_t;

endpackage

`default_nettype wire

// ===== design/etr_ctrl.sv =====
// Event trigger recorder controller: sequences decode, per-definition match
// steps, trailing push and result hand-off. Uses etr_pkg.
`default_nettype none

module etr_ctrl #(
  parameter int unsigned EVENT_COUNT = etr_pkg::EventCountDefault
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  input  wire etr_pkg::status_t sts_i,
  output etr_pkg::cmd_t        cmd_o
);

  etr_pkg::state_e state_q, state_d;
  logic [etr_pkg::EvtIdxW-1:0] idx_q, idx_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != etr_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    cmd_o         = '0;
    cmd_o.evt_idx = idx_q;
    case (state_q)
      etr_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = etr_pkg::ST_DECODE;
        end
      end
      etr_pkg::ST_DECODE: begin
        idx_d   = '0;
        state_d = etr_pkg::ST_DONE;
        case (sts_i.req_type)
          etr_pkg::REQ_SAMPLE: begin
            if (!sts_i.smp_zero) begin
              state_d = etr_pkg::ST_MATCH;
            end
          end
          etr_pkg::REQ_READ: begin
            cmd_o.rd_issue = !sts_i.empty;
          end
          etr_pkg::REQ_CLEAR: begin
            cmd_o.clear_buf = 1'b1;
          end
          default: ;
        endcase
      end
      etr_pkg::ST_MATCH: begin
        cmd_o.step = 1'b1;
        idx_d      = idx_q + 1'b1;
        if (idx_q == etr_pkg::EvtIdxW'(EVENT_COUNT - 1)) begin
          state_d = etr_pkg::ST_TAIL;
        end
      end
      etr_pkg::ST_TAIL: begin
        cmd_o.tail = 1'b1;
        state_d    = etr_pkg::ST_DONE;
      end
      etr_pkg::ST_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = etr_pkg::ST_IDLE;
        end
      end
      default: state_d = etr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= etr_pkg::ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/etr_datapath.sv =====
// Event trigger recorder datapath: event definitions, matcher, mode and
// overflow registers, ring buffer memory and result register. Uses etr_pkg.
`default_nettype none

module etr_datapath #(
  parameter int unsigned RING_DEPTH = etr_pkg::RingDepthDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire etr_pkg::in_word_t           in_word_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [etr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [etr_pkg::DefW-1:0]    cfg_wdata_i,
  input  wire etr_pkg::cmd_t               cmd_i,
  output etr_pkg::status_t                 sts_o,
  output etr_pkg::out_word_t               out_word_o
);

  localparam int unsigned PtrW = $clog2(RING_DEPTH);

  logic [etr_pkg::DefW-1:0] defs_q [etr_pkg::DefSlots];

  logic [1:0]                  req_q;
  logic [63:0]                 smp_q;
  logic [etr_pkg::LineW-1:0]   prev_q;
  logic [etr_pkg::ModeW-1:0]   mode_q, mode_d;
  logic [7:0]                  ovf_q, ovf_d;
  logic [PtrW-1:0]             wp_q, wp_d, rp_q, rp_d;
  logic [7:0]                  match_q;
  logic [3:0]                  tries_q;
  logic                        rvalid_q;
  logic [63:0]                 rdata_q;
  etr_pkg::out_word_t          out_q;

  logic [63:0] mem [RING_DEPTH];

  logic [etr_pkg::DefW-1:0]  def_sel;
  logic [7:0]                act;
  logic [etr_pkg::LineW-1:0] dc, pp, cp, cur;
  logic                      hit;
  logic                      push;
  logic                      full;
  logic                      wr_en;
  logic [PtrW:0]             wp_inc, rp_inc;
  logic [PtrW-1:0]           wp_nx, rp_nx;

  assign wp_inc = {1'b0, wp_q} + 1'b1;
  assign rp_inc = {1'b0, rp_q} + 1'b1;
  assign wp_nx  = (wp_inc >= (PtrW + 1)'(RING_DEPTH)) ? '0 : wp_inc[PtrW-1:0];
  assign rp_nx  = (rp_inc >= (PtrW + 1)'(RING_DEPTH)) ? '0 : rp_inc[PtrW-1:0];
  assign full   = (wp_nx == rp_q);

  assign def_sel = defs_q[cmd_i.evt_idx];
  assign act     = def_sel[55:48];
  assign dc      = def_sel[47:32];
  assign pp      = def_sel[31:16];
  assign cp      = def_sel[15:0];
  assign cur     = smp_q[63:48];
  assign hit     = ((prev_q | dc) == pp) && ((cur | dc) == cp);

  // mode update happens before the push decision of the same definition
  always_comb begin
    mode_d = mode_q;
    push   = 1'b0;
    if (cmd_i.step && hit) begin
      if (act != 8'd0) begin
        mode_d = act[7:1];
      end
      push = (mode_d == etr_pkg::ModeW'(1)) || (act != 8'd0);
    end
    if (cmd_i.tail) begin
      push = (mode_q == etr_pkg::ModeW'(3));
    end
  end

  assign wr_en = push && !full;

  always_comb begin
    ovf_d = ovf_q;
    wp_d  = wp_q;
    rp_d  = rp_q;
    if (push) begin
      if (full) begin
        ovf_d = ovf_q + 8'd1;
      end else begin
        wp_d = wp_nx;
      end
    end
    if (cmd_i.rd_issue) begin
      rp_d = rp_nx;
    end
    if (cmd_i.clear_buf) begin
      rp_d = wp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < int'(etr_pkg::DefSlots); k++) begin
        defs_q[k] <= (k == 0) ? etr_pkg::Def0Reset : '0;
      end
    end else if (cfg_we_i && (cfg_idx_i < etr_pkg::CfgIdxW'(etr_pkg::DefSlots))) begin
      defs_q[cfg_idx_i[etr_pkg::EvtIdxW-1:0]] <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      mode_q <= '0;
      ovf_q  <= '0;
      wp_q   <= '0;
      rp_q   <= '0;
    end else begin
      mode_q <= mode_d;
      ovf_q  <= ovf_d;
      wp_q   <= wp_d;
      rp_q   <= rp_d;
      if (cmd_i.tail) begin
        prev_q <= cur;
      end
    end
  end

  // per-item registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q    <= in_word_i.req_type;
      smp_q    <= in_word_i.sample;
      match_q  <= '0;
      tries_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (cmd_i.step && hit) begin
        match_q[cmd_i.evt_idx] <= 1'b1;
      end
      if (push) begin
        tries_q <= tries_q + 4'd1;
      end
      if (cmd_i.rd_issue) begin
        rvalid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wp_q] <= smp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) begin
      rdata_q <= mem[rp_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.read_valid     <= rvalid_q;
      out_q.read_data      <= rvalid_q ? rdata_q : 64'd0;
      out_q.mode           <= mode_q;
      out_q.overflow_count <= ovf_q;
      out_q.match_bits     <= match_q;
      out_q.pushes_tried   <= tries_q;
    end
  end

  assign out_word_o     = out_q;
  assign sts_o.req_type = req_q;
  assign sts_o.smp_zero = (smp_q == 64'd0);
  assign sts_o.empty    = (rp_q == wp_q);

endmodule

`default_nettype wire

// ===== design/event_trigger_recorder.sv =====
// Event trigger recorder top level: ties the controller to the datapath.
// Depends on etr_pkg, etr_ctrl, etr_datapath.
//
//   channel  direction  handshake                  word
//   in       input      in_valid_i / in_stall_o    etr_pkg::in_word_t
//   out      output     out_valid_o / out_stall_i  etr_pkg::out_word_t
//   cfg      input      cfg_we_i, cfg_idx_i        cfg_wdata_i (56 bits)
//
// A nonzero sample passes through decode, a match step per event definition, the trailing
// push and the result load between one accept and the next; the single write port of the
// ring memory takes one push per cycle.
// Read, clear, zero samples and unused codes go from decode straight to the result load.
// The next word is accepted while a result still waits on out_stall_i; the block
// then holds before loading a new result. Reset is async; the ring memory is not
// cleared, pointers and mode reset to zero.
`default_nettype none

module event_trigger_recorder #(
  parameter int unsigned RING_DEPTH  = etr_pkg::RingDepthDefault,
  parameter int unsigned EVENT_COUNT = etr_pkg::EventCountDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire etr_pkg::in_word_t           in_word_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output etr_pkg::out_word_t               out_word_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [etr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [etr_pkg::DefW-1:0]    cfg_wdata_i
);

  etr_pkg::cmd_t    cmd;
  etr_pkg::status_t sts;

  etr_ctrl #(
    .EVENT_COUNT(EVENT_COUNT)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  etr_datapath #(
    .RING_DEPTH(RING_DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_word_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_word_o (out_word_o)
  );

endmodule

`default_nettype wire

// ===== design/etr_checker.sv =====
// Port-level checks for the event trigger recorder, bound to the top level.
// Depends on etr_pkg and event_trigger_recorder.
`default_nettype none

module etr_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire etr_pkg::out_word_t out_word_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("out valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_word_o))
    else $error("out word changed while stalled");

  // one word in flight: the input closes right after an accept
  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted back to back");

  a_read_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.read_valid |->
      out_word_o.match_bits == 8'd0 && out_word_o.pushes_tried == 4'd0)
    else $error("read word carries match results");

  a_tries_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.pushes_tried <= 4'd9)
    else $error("too many push attempts");

endmodule

bind event_trigger_recorder etr_checker u_etr_checker (.*);

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for event_trigger_recorder: directed words, then random phases
// under several trigger setups, checked against an in-bench model of the recorder.
// Depends on etr_pkg and the event_trigger_recorder RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RingDepth = etr_pkg::RingDepthDefault;
  localparam int unsigned EventCount = etr_pkg::EventCountDefault;
  localparam int QuietLimit = 4000;
  localparam int TailCycles = 2 * (EventCount + 4);
  localparam int MaxReports = 10;
  localparam int NumPhases = 8;
  localparam int NumDirected = 20;

  localparam logic [1:0] ReqUnused = 2'd3;
  localparam logic [6:0] ModeEveryMatch = 7'd1;
  localparam logic [6:0] ModeDoublePush = 7'd3;

  typedef struct packed {
    logic [7:0]  action;
    logic [15:0] dont_care;
    logic [15:0] prev_pat;
    logic [15:0] cur_pat;
  } event_def_t;

  typedef enum logic [1:0] {
    DEFS_MIXED,
    DEFS_FLOOD,
    DEFS_EXTREME
  } def_plan_e;

  typedef struct packed {
    etr_pkg::in_word_t  word;
    logic               typed;
    etr_pkg::out_word_t want;
  } dir_row_t;

  localparam etr_pkg::out_word_t AllZero = '0;
  localparam etr_pkg::out_word_t EmptyTopMode = '{read_valid: 1'b0, read_data: 64'h0,
                                                 mode: 7'h7F, overflow_count: 8'h0,
                                                 match_bits: 8'h0, pushes_tried: 4'h0};

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  etr_pkg::in_word_t             in_word = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  etr_pkg::out_word_t            out_word;
  logic                          cfg_we = 1'b0;
  logic [etr_pkg::CfgIdxW-1:0]   cfg_idx = '0;
  logic [etr_pkg::DefW-1:0]      cfg_wdata = '0;

  // recorder model state
  event_def_t           event_defs [etr_pkg::DefSlots];
  logic [15:0]          last_lines;
  logic [6:0]           rec_mode;
  logic [7:0]           ovf_count;
  logic [63:0]          ring_mem [RingDepth];
  int unsigned          head_ptr;
  int unsigned          tail_ptr;

  etr_pkg::out_word_t   result_words [$];
  logic [15:0]          line_set [4];
  int                   send_idle_pct = 0;
  int                   stall_pct = 0;
  int                   fail_count = 0;
  int                   quiet_cycles = 0;
  int                   words_sent = 0;
  int                   results_seen = 0;
  int                   lost_pushes = 0;
  int                   read_hits = 0;

  dir_row_t directed_rows [NumDirected] = '{
    '{'{etr_pkg::REQ_READ,   64'h0},                  1'b1, AllZero},
    '{'{etr_pkg::REQ_CLEAR,  64'h0},                  1'b1, AllZero},
    '{'{ReqUnused,           64'hFFFF_FFFF_FFFF_FFFF}, 1'b1, AllZero},
    '{'{etr_pkg::REQ_SAMPLE, 64'h0},                  1'b1, AllZero},
    '{'{etr_pkg::REQ_SAMPLE, 64'h0000_0000_0000_0001}, 1'b0, AllZero},
    '{'{etr_pkg::REQ_SAMPLE, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b0, AllZero},
    '{'{etr_pkg::REQ_SAMPLE, 64'h0000_0000_0000_0001}, 1'b0, AllZero},
    '{'{etr_pkg::REQ_READ,   64'hFFFF_FFFF_FFFF_FFFF}, 1'b0, AllZero},
    '{'{etr_pkg::REQ_READ,   64'h0},                  1'b1, EmptyTopMode},
    '{'{etr_pkg::REQ_SAMPLE, 64'h8000_0000_0000_0000}, 1'b0, AllZero},
    '{'{etr_pkg::REQ_SAMPLE, 64'h0000_FFFF_FFFF_FFFF}, 1'b0, AllZero},
    '{'{etr_pkg::REQ_SAMPLE, 64'h0000_0000_0000_8000}, 1'b0, AllZero},
    '{'{etr_pkg::REQ_CLEAR,  64'h0},                  1'b0, AllZero},
    '{'{etr_pkg::REQ_READ,   64'h0},                  1'b1, EmptyTopMode},
    '{'{ReqUnused,           64'h5A5A_A5A5_5A5A_A5A5}, 1'b0, AllZero},
    '{'{etr_pkg::REQ_SAMPLE, 64'h0001_0000_0000_0000}, 1'b0, AllZero},
    '{'{etr_pkg::REQ_READ,   64'h0},                  1'b0, AllZero},
    '{'{etr_pkg::REQ_SAMPLE, 64'hFFFF_0000_0000_0000}, 1'b0, AllZero},
    '{'{etr_pkg::REQ_CLEAR,  64'h0},                  1'b0, AllZero},
    '{'{etr_pkg::REQ_READ,   64'h0},                  1'b0, AllZero}
  };

  event_trigger_recorder i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= rst_n && (int'($urandom_range(99)) < stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ring push; a full ring drops the word and bumps the overflow count
  function automatic void ring_push(input logic [63:0] w);
    int unsigned nxt;
    nxt = (tail_ptr + 1 >= RingDepth) ? 0 : tail_ptr + 1;
    if (nxt == head_ptr) begin
      ovf_count = ovf_count + 8'd1;
      lost_pushes++;
    end else begin
      ring_mem[tail_ptr] = w;
      tail_ptr = nxt;
    end
  endfunction

  function automatic etr_pkg::out_word_t record_step(input etr_pkg::in_word_t w);
    etr_pkg::out_word_t r;
    logic [15:0] cur;
    event_def_t d;
    r = '0;
    case (w.req_type)
      etr_pkg::REQ_SAMPLE: begin
        if (w.sample != '0) begin
          cur = w.sample[63:48];
          for (int t = 0; t < EventCount; t++) begin
            d = event_defs[t];
            if (((last_lines | d.dont_care) == d.prev_pat) &&
                ((cur | d.dont_care) == d.cur_pat)) begin
              r.match_bits[t] = 1'b1;
              if (d.action != '0) rec_mode = d.action[7:1];
              if (rec_mode == ModeEveryMatch || d.action != '0) begin
                ring_push(w.sample);
                r.pushes_tried = r.pushes_tried + 4'd1;
              end
            end
          end
          // trailing push after the definition loop
          if (rec_mode == ModeDoublePush) begin
            ring_push(w.sample);
            r.pushes_tried = r.pushes_tried + 4'd1;
          end
          last_lines = cur;
        end
      end
      etr_pkg::REQ_READ: begin
        if (head_ptr != tail_ptr) begin
          r.read_valid = 1'b1;
          r.read_data = ring_mem[head_ptr];
          head_ptr = (head_ptr + 1 >= RingDepth) ? 0 : head_ptr + 1;
          read_hits++;
        end
      end
      etr_pkg::REQ_CLEAR: head_ptr = tail_ptr;
      default: ;
    endcase
    r.mode = rec_mode;
    r.overflow_count = ovf_count;
    return r;
  endfunction

  // Holds the word until accepted; valid stays high for the next word unless it idles.
  task automatic send_word(input etr_pkg::in_word_t w, input logic typed,
                           input etr_pkg::out_word_t want);
    etr_pkg::out_word_t calc;
    while (int'($urandom_range(99)) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    calc = record_step(w);
    result_words.push_back(typed ? want : calc);
    words_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (result_words.size() != 0) @(posedge clk);
  endtask

  task automatic load_defs(input def_plan_e plan);
    event_def_t fresh [etr_pkg::DefSlots];
    logic [15:0] mask;
    foreach (line_set[k]) line_set[k] = 16'($urandom);
    if (plan == DEFS_EXTREME) begin
      line_set[0] = 16'h0000;
      line_set[1] = 16'hFFFF;
    end
    for (int t = 0; t < etr_pkg::DefSlots; t++) begin
      case (plan)
        DEFS_FLOOD: begin
          // always matches, every definition pushes, mode 3 adds the trailing push
          fresh[t] = '{action: {ModeDoublePush, 1'($urandom)}, dont_care: 16'hFFFF,
                       prev_pat: 16'hFFFF, cur_pat: 16'hFFFF};
        end
        DEFS_EXTREME: fresh[t] = (t % 2 == 0) ? '1 : '0;
        default: begin
          case ($urandom_range(3))
            0: mask = '0;
            1: mask = 16'($urandom & $urandom);
            2: mask = 16'($urandom);
            default: mask = 16'($urandom | $urandom);
          endcase
          fresh[t].dont_care = mask;
          if ($urandom_range(9) == 0) begin
            fresh[t].prev_pat = 16'($urandom);
            fresh[t].cur_pat = 16'($urandom);
          end else begin
            fresh[t].prev_pat = line_set[$urandom_range(3)] | mask;
            fresh[t].cur_pat = line_set[$urandom_range(3)] | mask;
          end
          case ($urandom_range(9))
            0, 1, 2: fresh[t].action = '0;
            3, 4, 5: fresh[t].action = {ModeEveryMatch, 1'($urandom)};
            6: fresh[t].action = {ModeDoublePush, 1'($urandom)};
            default: fresh[t].action = 8'($urandom);
          endcase
        end
      endcase
    end
    // last write goes to an unused index and must change nothing
    for (int t = 0; t <= etr_pkg::DefSlots; t++) begin
      cfg_we <= 1'b1;
      if (t < etr_pkg::DefSlots) begin
        cfg_idx <= etr_pkg::CfgIdxW'(t);
        cfg_wdata <= fresh[t];
      end else begin
        cfg_idx <= etr_pkg::CfgIdxW'(etr_pkg::DefSlots +
                                     $urandom_range(etr_pkg::DefSlots - 1));
        cfg_wdata <= etr_pkg::DefW'({$urandom, $urandom});
      end
      @(posedge clk);
      if (t < etr_pkg::DefSlots) event_defs[t] = fresh[t];
    end
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int items, input int read_pct, input int clear_pct);
    etr_pkg::in_word_t w;
    int roll;
    for (int i = 0; i < items; i++) begin
      if (i == items / 2) drain_results();
      roll = int'($urandom_range(99));
      w.sample = {$urandom, $urandom};
      if (roll < read_pct) begin
        w.req_type = etr_pkg::REQ_READ;
      end else if (roll < read_pct + clear_pct) begin
        w.req_type = etr_pkg::REQ_CLEAR;
      end else if (roll < read_pct + clear_pct + 2) begin
        w.req_type = ReqUnused;
      end else begin
        w.req_type = etr_pkg::REQ_SAMPLE;
        if ($urandom_range(4) != 0) w.sample[63:48] = line_set[$urandom_range(3)];
        if ($urandom_range(19) == 0) w.sample = '0;
      end
      send_word(w, 1'b0, AllZero);
    end
    drain_results();
  endtask

  always @(posedge clk) begin : check_results
    etr_pkg::out_word_t due;
    if (rst_n && out_valid && !out_stall) begin
      if (result_words.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports) $display("unexpected result word %h", out_word);
      end else begin
        due = result_words.pop_front();
        results_seen++;
        if (out_word.read_valid !== due.read_valid || out_word.read_data !== due.read_data ||
            out_word.mode !== due.mode || out_word.overflow_count !== due.overflow_count ||
            out_word.match_bits !== due.match_bits ||
            out_word.pushes_tried !== due.pushes_tried) begin
          fail_count++;
          if (fail_count <= MaxReports) begin
            $display("result %0d: exp rv=%0b data=%h mode=%0d ovf=%0d match=%h tries=%0d",
                     results_seen, due.read_valid, due.read_data, due.mode,
                     due.overflow_count, due.match_bits, due.pushes_tried);
            $display("           got rv=%0b data=%h mode=%0d ovf=%0d match=%h tries=%0d",
                     out_word.read_valid, out_word.read_data, out_word.mode,
                     out_word.overflow_count, out_word.match_bits, out_word.pushes_tried);
          end
        end
      end
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= QuietLimit);
    $display("event_trigger_recorder: mismatch");
    $finish;
  end

  initial begin : stimulus
    def_plan_e plan;
    int items;
    int read_pct;
    int clear_pct;
    foreach (event_defs[t]) event_defs[t] = '0;
    event_defs[0] = etr_pkg::Def0Reset;
    last_lines = '0;
    rec_mode = '0;
    ovf_count = '0;
    head_ptr = 0;
    tail_ptr = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
    end
    drain_results();

    // phase 2 floods the ring until it is full and the overflow count wraps
    for (int p = 0; p < NumPhases; p++) begin
      plan = (p == 2) ? DEFS_FLOOD : (p == 5) ? DEFS_EXTREME : DEFS_MIXED;
      items = (p == 2) ? 320 : (p >= 5) ? 140 : 170;
      read_pct = (p == 2) ? 5 : (p == 3) ? 45 : 20;
      clear_pct = (p == 2) ? 0 : 3;
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 59; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 59; end
        default: begin send_idle_pct = 15; stall_pct = 15; end
      endcase
      load_defs(plan);
      run_phase(items, read_pct, clear_pct);
    end

    repeat (TailCycles) @(posedge clk);
    if (result_words.size() != 0) fail_count++;
    $display("sent %0d words over %0d setups, %0d results checked, %0d failures",
             words_sent, NumPhases + 1, results_seen, fail_count);
    $display("ring reads with data: %0d, pushes dropped on a full ring: %0d",
             read_hits, lost_pushes);
    if (fail_count == 0) begin
      $display("event_trigger_recorder: match");
    end else begin
      $display("event_trigger_recorder: mismatch");
    end
    $finish;
  end

endmodule
